### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers included by stack_machine_execute_unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check an implication on every clock edge outside reset.
`define SME_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Check that a condition never holds outside reset.
`define SME_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define SME_ASSERT(lbl, clk, rst_n, prop)
`define SME_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### rtl/sme_pkg.sv
// ----------------------------------------------------------------------------
// sme_pkg
// Shared sizes, opcodes and interface types of the stack machine unit.
// ----------------------------------------------------------------------------
package sme_pkg;

	localparam int DS_DEPTH  = 256;
	localparam int RS_DEPTH  = 64;
	localparam int REG_COUNT = 8;
	localparam int RAM_WORDS = 1024;
	localparam int VRAM_BYTES = 4096;
	localparam int PC_BITS   = 16;

	localparam int DS_AW   = $clog2(DS_DEPTH);
	localparam int RS_AW   = $clog2(RS_DEPTH);
	localparam int REG_AW  = $clog2(REG_COUNT);
	localparam int RAM_AW  = $clog2(RAM_WORDS);
	localparam int VRAM_AW = $clog2(VRAM_BYTES);

	localparam logic [7:0] VRAM_FILL = 8'h20;

	typedef enum logic [4:0] {
		OP_NOP    = 5'd0,
		OP_HLT    = 5'd1,
		OP_PUSH   = 5'd2,
		OP_POP    = 5'd3,
		OP_OUT    = 5'd4,
		OP_ADD    = 5'd5,
		OP_SUB    = 5'd6,
		OP_MUL    = 5'd7,
		OP_DIV    = 5'd8,
		OP_QROOT  = 5'd9,
		OP_SQ     = 5'd10,
		OP_PUSHR  = 5'd11,
		OP_POPR   = 5'd12,
		OP_IN     = 5'd13,
		OP_TOPOUT = 5'd14,
		OP_JMP    = 5'd15,
		OP_CALL   = 5'd16,
		OP_RET    = 5'd17,
		OP_PUSHM  = 5'd18,
		OP_POPM   = 5'd19,
		OP_PUSHVM = 5'd20,
		OP_POPVM  = 5'd21,
		OP_JB     = 5'd22,
		OP_JBE    = 5'd23,
		OP_JA     = 5'd24,
		OP_JAE    = 5'd25,
		OP_JE     = 5'd26,
		OP_JNE    = 5'd27
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_BAD   = 2'd1,
		ST_UNDER = 2'd2,
		ST_OVER  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		AR_MUL  = 3'b001,
		AR_DIV  = 3'b010,
		AR_SQRT = 3'b100
	} arith_op_t;

	typedef struct packed {
		logic      start;
		arith_op_t op;
	} arith_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] result;
	} arith_rsp_t;

	typedef struct packed {
		logic               ram_we;
		logic               vram_we;
		logic [VRAM_AW-1:0] addr;
		logic [63:0]        data;
	} mem_wr_t;

endpackage

### rtl/sme_ram.sv
// ----------------------------------------------------------------------------
// sme_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sme_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/sme_mem_store.sv
// ----------------------------------------------------------------------------
// sme_mem_store
// Word RAM and byte video RAM, with the clearing sweep after reset.
// ----------------------------------------------------------------------------
module sme_mem_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [sme_pkg::VRAM_AW-1:0] rd_addr,
	input  sme_pkg::mem_wr_t          wr,
	output logic [63:0]               ram_rdata,
	output logic [7:0]                vram_rdata,
	output logic                      clearing
);
	import sme_pkg::*;

	localparam logic [VRAM_AW-1:0] CLR_LAST = VRAM_AW'(VRAM_BYTES - 1);

	logic [63:0]        ram_mem  [RAM_WORDS];
	logic [7:0]         vram_mem [VRAM_BYTES];
	logic [63:0]        ram_rd_q;
	logic [7:0]         vram_rd_q;
	logic               clr_q;
	logic [VRAM_AW-1:0] clr_cnt_q;

	// sweep every entry once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == CLR_LAST) begin
				clr_q <= 1'b0;
			end
		end
	end

	// memory writes and registered reads
	always_ff @(posedge clk) begin
		if (clr_q) begin
			if (clr_cnt_q[VRAM_AW-1:RAM_AW] == '0) begin
				ram_mem[clr_cnt_q[RAM_AW-1:0]] <= 64'd0;
			end
			vram_mem[clr_cnt_q] <= VRAM_FILL;
		end else begin
			if (wr.ram_we) begin
				ram_mem[wr.addr[RAM_AW-1:0]] <= wr.data;
			end
			if (wr.vram_we) begin
				vram_mem[wr.addr] <= wr.data[7:0];
			end
		end
		if (rd_en) begin
			ram_rd_q  <= ram_mem[rd_addr[RAM_AW-1:0]];
			vram_rd_q <= vram_mem[rd_addr];
		end
	end

	assign ram_rdata  = ram_rd_q;
	assign vram_rdata = vram_rd_q;
	assign clearing   = clr_q;

endmodule

### rtl/sme_arith.sv
// ----------------------------------------------------------------------------
// sme_arith
// Multi-cycle unit: 64-bit multiply (32x32 partial products), signed
// restoring divide (one bit a cycle) and floor square root (one bit a cycle).
// ----------------------------------------------------------------------------
module sme_arith (
	input  logic                clk,
	input  logic                arst_n,
	input  sme_pkg::arith_req_t req,
	input  logic [63:0]         opa,
	input  logic [63:0]         opb,
	output sme_pkg::arith_rsp_t rsp
);
	import sme_pkg::*;

	typedef enum logic [1:0] {
		A_IDLE = 2'b01,
		A_RUN  = 2'b10
	} astate_t;

	localparam logic [5:0] MUL_LAST  = 6'd3;
	localparam logic [5:0] DIV_LAST  = 6'd63;
	localparam logic [5:0] SQRT_LAST = 6'd31;

	astate_t     state_q;
	arith_op_t   op_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic        neg_q;
	logic [63:0] work_q;
	logic [63:0] acc_q;
	logic [63:0] rem_q;
	logic [63:0] prod_q;
	logic [63:0] opa_q;
	logic [63:0] opb_q;

	logic [31:0] mul_x;
	logic [31:0] mul_y;
	logic [63:0] prod_w;
	logic [64:0] div_sh;
	logic [64:0] div_sub;
	logic        div_ge;
	logic [65:0] sq_sh;
	logic [65:0] sq_trial;
	logic [65:0] sq_sub;
	logic        sq_ge;
	logic [5:0]  last;

	// select partial product operands
	always_comb begin
		unique case (cnt_q[1:0])
			2'd0: begin
				mul_x = opa_q[31:0];
				mul_y = opb_q[31:0];
			end
			2'd1: begin
				mul_x = opa_q[31:0];
				mul_y = opb_q[63:32];
			end
			default: begin
				mul_x = opa_q[63:32];
				mul_y = opb_q[31:0];
			end
		endcase
	end

	assign prod_w = mul_x * mul_y;

	// one restoring divide step
	assign div_sh  = {rem_q, work_q[63]};
	assign div_ge  = div_sh >= {1'b0, opb_q};
	assign div_sub = div_sh - {1'b0, opb_q};

	// one square root digit
	assign sq_sh    = {rem_q, work_q[63:62]};
	assign sq_trial = {32'd0, acc_q[31:0], 2'b01};
	assign sq_ge    = sq_sh >= sq_trial;
	assign sq_sub   = sq_sh - sq_trial;

	always_comb begin
		unique case (op_q)
			AR_MUL:  last = MUL_LAST;
			AR_DIV:  last = DIV_LAST;
			default: last = SQRT_LAST;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						state_q <= A_RUN;
						cnt_q   <= '0;
					end
				end
				default: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == last) begin
						state_q <= A_IDLE;
						done_q  <= 1'b1;
					end
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == A_IDLE) begin
			if (req.start) begin
				op_q  <= req.op;
				neg_q <= opa[63] ^ opb[63];
				opa_q <= opa;
				acc_q <= '0;
				rem_q <= '0;
				if (req.op == AR_DIV) begin
					opb_q  <= opb[63] ? (64'd0 - opb) : opb;
					work_q <= opa[63] ? (64'd0 - opa) : opa;
				end else begin
					opb_q  <= opb;
					work_q <= opa;
				end
			end
		end else begin
			unique case (op_q)
				AR_MUL: begin
					prod_q <= prod_w;
					if (cnt_q == 6'd1) begin
						acc_q <= prod_q;
					end else if (cnt_q != 6'd0) begin
						acc_q <= acc_q + {prod_q[31:0], 32'd0};
					end
				end
				AR_DIV: begin
					rem_q  <= div_ge ? div_sub[63:0] : div_sh[63:0];
					work_q <= {work_q[62:0], div_ge};
				end
				default: begin
					rem_q  <= sq_ge ? sq_sub[63:0] : sq_sh[63:0];
					acc_q  <= {acc_q[62:0], sq_ge};
					work_q <= {work_q[61:0], 2'b00};
				end
			endcase
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = (op_q == AR_DIV) ? (neg_q ? (64'd0 - work_q) : work_q) : acc_q;

endmodule

### rtl/stack_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// Executes one stack-machine instruction per command and reports its result.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: drive the instruction fields and raise start; the
//    command transfers at a clock edge with start high and busy low.
//  - Result channel: done is high for exactly one cycle with status,
//    redirect, next_pc, halted, out_valid and out_value. The receiver cannot
//    stall it, so it must take the result in that cycle.
//  - Config channel: cfg_data (program_length) transfers when cfg_valid is
//    high; cfg_ready is always high. Write it only while the unit is idle.
//  - Sequencing: the stacks are read into registers at the transfer, S_EXEC
//    registers the result, shown while done is high; a new command can be
//    taken at the edge that ends it, but none while the unit is busy.
//  - MUL, SQ, QROOT and DIV (non-zero divisor) wait in S_WAIT for the
//    multi-cycle unit, which resolves 32x32 partial products or one bit a cycle.
//  - Reset: stacks empty, registers zero; busy stays high while the word
//    RAM is swept to zero and the video RAM to spaces.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stack_machine_execute_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [4:0]          action,
	input  logic signed [63:0]  operand,
	input  logic                has_operand,
	input  logic [15:0]         current_pc,
	input  logic signed [63:0]  input_value,
	input  logic                input_ok,
	output logic                done,
	output sme_pkg::status_t    status,
	output logic                redirect,
	output logic [15:0]         next_pc,
	output logic                halted,
	output logic                out_valid,
	output logic signed [63:0]  out_value,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);
	import sme_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_EXEC  = 4'b0100,
		S_WAIT  = 4'b1000
	} state_t;

	localparam logic [DS_AW:0] DS_FULL = (DS_AW+1)'(DS_DEPTH);
	localparam logic [RS_AW:0] RS_FULL = (RS_AW+1)'(RS_DEPTH);

	state_t              state_q;
	logic [DS_AW:0]      depth_q;
	logic [RS_AW:0]      rdepth_q;
	logic [31:0]         regs_q [REG_COUNT];
	logic [15:0]         prog_len_q;

	// latched command
	opcode_t             act_q;
	logic [63:0]         opnd_q;
	logic                has_q;
	logic [15:0]         pc_q;
	logic [63:0]         inval_q;
	logic                inok_q;
	logic [31:0]         rv_q;
	logic                reg_ok_q;
	logic                ram_ok_q;
	logic                vram_ok_q;
	logic [REG_AW-1:0]   idx_q;
	logic [VRAM_AW-1:0]  maddr_q;

	// registered result
	logic                done_q;
	status_t             status_q;
	logic                redir_q;
	logic [15:0]         npc_q;
	logic                halt_q;
	logic                ov_q;
	logic [63:0]         oval_q;

	logic                accept;
	logic [31:0]         rv;
	logic                reg_ok;
	logic [DS_AW:0]      dm1;
	logic [DS_AW:0]      dm2;
	logic [RS_AW:0]      rm1;
	logic [63:0]         top0;
	logic [63:0]         top1;
	logic [15:0]         ret_rd;
	logic [63:0]         ram_rd;
	logic [7:0]          vram_rd;
	logic                clearing;

	// execute stage decisions
	status_t             st;
	logic                redir;
	logic [15:0]         npc;
	logic                halt;
	logic                ov;
	logic [63:0]         oval;
	logic                do_push;
	logic [63:0]         push_val;
	logic                ds_we;
	logic [DS_AW-1:0]    ds_waddr;
	logic [63:0]         ds_wdata;
	logic [DS_AW:0]      depth_nxt;
	logic                rs_we;
	logic [RS_AW:0]      rdepth_nxt;
	logic                reg_we;
	logic                go_arith;
	arith_op_t           arith_op;
	logic [63:0]         arith_a;
	logic [63:0]         arith_b;
	logic                take_cmp;
	mem_wr_t             mwr;
	arith_req_t          areq;
	arith_rsp_t          arsp;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// decode register and address operands at transfer
	assign rv     = regs_q[operand[REG_AW-1:0]];
	assign reg_ok = has_operand && (operand[63:REG_AW] == '0);
	assign dm1    = depth_q - 1'b1;
	assign dm2    = depth_q - 2'd2;
	assign rm1    = rdepth_q - 1'b1;

	sme_ram #(.WIDTH(64), .DEPTH(DS_DEPTH)) u_ds_top (
		.clk   (clk),
		.we    (ds_we),
		.waddr (ds_waddr),
		.wdata (ds_wdata),
		.re    (accept),
		.raddr (dm1[DS_AW-1:0]),
		.rdata (top0)
	);

	sme_ram #(.WIDTH(64), .DEPTH(DS_DEPTH)) u_ds_next (
		.clk   (clk),
		.we    (ds_we),
		.waddr (ds_waddr),
		.wdata (ds_wdata),
		.re    (accept),
		.raddr (dm2[DS_AW-1:0]),
		.rdata (top1)
	);

	sme_ram #(.WIDTH(16), .DEPTH(RS_DEPTH)) u_rs (
		.clk   (clk),
		.we    (rs_we),
		.waddr (rdepth_q[RS_AW-1:0]),
		.wdata (pc_q),
		.re    (accept),
		.raddr (rm1[RS_AW-1:0]),
		.rdata (ret_rd)
	);

	sme_mem_store u_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (accept),
		.rd_addr    (rv[VRAM_AW-1:0]),
		.wr         (mwr),
		.ram_rdata  (ram_rd),
		.vram_rdata (vram_rd),
		.clearing   (clearing)
	);

	assign areq.start = go_arith;
	assign areq.op    = arith_op;

	sme_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (areq),
		.opa    (arith_a),
		.opb    (arith_b),
		.rsp    (arsp)
	);

	// signed compare for conditional jumps
	always_comb begin
		unique case (act_q)
			OP_JB:   take_cmp = $signed(top1) <  $signed(top0);
			OP_JBE:  take_cmp = $signed(top1) <= $signed(top0);
			OP_JA:   take_cmp = $signed(top1) >  $signed(top0);
			OP_JAE:  take_cmp = $signed(top1) >= $signed(top0);
			OP_JE:   take_cmp = top1 == top0;
			default: take_cmp = top1 != top0;
		endcase
	end

	// execute one instruction
	always_comb begin
		st         = ST_OK;
		redir      = 1'b0;
		npc        = '0;
		halt       = 1'b0;
		ov         = 1'b0;
		oval       = '0;
		do_push    = 1'b0;
		push_val   = '0;
		ds_we      = 1'b0;
		ds_waddr   = depth_q[DS_AW-1:0];
		ds_wdata   = '0;
		depth_nxt  = depth_q;
		rs_we      = 1'b0;
		rdepth_nxt = rdepth_q;
		reg_we     = 1'b0;
		go_arith   = 1'b0;
		arith_op   = AR_MUL;
		arith_a    = top1;
		arith_b    = top0;
		mwr.ram_we  = 1'b0;
		mwr.vram_we = 1'b0;
		mwr.addr    = maddr_q;
		mwr.data    = top0;

		if (state_q == S_EXEC) begin
			unique case (act_q)
				OP_NOP: ;
				OP_HLT: begin
					halt  = 1'b1;
					redir = 1'b1;
					npc   = prog_len_q;
				end
				OP_PUSH: begin
					if (has_q) begin
						do_push  = 1'b1;
						push_val = opnd_q;
					end else begin
						st = ST_BAD;
					end
				end
				OP_POP, OP_OUT: begin
					if (depth_q == '0) begin
						st = ST_UNDER;
					end else begin
						depth_nxt = dm1;
						if (act_q == OP_OUT) begin
							ov   = 1'b1;
							oval = top0;
						end
					end
				end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV,
				OP_JB, OP_JBE, OP_JA, OP_JAE, OP_JE, OP_JNE: begin
					if (act_q >= OP_JB && !has_q) begin
						st = ST_BAD;
					end else if (depth_q < 2'd2) begin
						st = ST_UNDER;
					end else begin
						depth_nxt = dm2;
						priority case (act_q)
							OP_ADD, OP_SUB: begin
								ds_we     = 1'b1;
								ds_waddr  = dm2[DS_AW-1:0];
								ds_wdata  = (act_q == OP_ADD) ? (top1 + top0) : (top1 - top0);
								depth_nxt = dm1;
							end
							OP_MUL: begin
								go_arith = 1'b1;
								arith_op = AR_MUL;
							end
							OP_DIV: begin
								if (top0 == '0) begin
									st = ST_BAD;
								end else begin
									go_arith = 1'b1;
									arith_op = AR_DIV;
								end
							end
							default: begin
								if (take_cmp) begin
									redir = 1'b1;
									npc   = opnd_q[15:0];
								end
							end
						endcase
					end
				end
				OP_QROOT, OP_SQ: begin
					if (depth_q == '0) begin
						st = ST_UNDER;
					end else begin
						depth_nxt = dm1;
						arith_a   = top0;
						if (act_q == OP_QROOT) begin
							if (top0[63]) begin
								st = ST_BAD;
							end else begin
								go_arith = 1'b1;
								arith_op = AR_SQRT;
							end
						end else begin
							go_arith = 1'b1;
							arith_op = AR_MUL;
						end
					end
				end
				OP_PUSHR: begin
					if (!reg_ok_q) begin
						st = ST_BAD;
					end else begin
						do_push  = 1'b1;
						push_val = {{32{rv_q[31]}}, rv_q};
					end
				end
				OP_POPR: begin
					if (!reg_ok_q) begin
						st = ST_BAD;
					end else if (depth_q == '0) begin
						st = ST_UNDER;
					end else begin
						reg_we    = 1'b1;
						depth_nxt = dm1;
					end
				end
				OP_IN: begin
					if (inok_q) begin
						do_push  = 1'b1;
						push_val = inval_q;
					end else begin
						st = ST_BAD;
					end
				end
				OP_TOPOUT: begin
					if (depth_q == '0) begin
						st = ST_UNDER;
					end else begin
						ov   = 1'b1;
						oval = top0;
					end
				end
				OP_JMP: begin
					if (has_q) begin
						redir = 1'b1;
						npc   = opnd_q[15:0];
					end else begin
						st = ST_BAD;
					end
				end
				OP_CALL: begin
					if (!has_q) begin
						st = ST_BAD;
					end else begin
						if (rdepth_q >= RS_FULL) begin
							st = ST_OVER;
						end else begin
							rs_we      = 1'b1;
							rdepth_nxt = rdepth_q + 1'b1;
						end
						redir = 1'b1;
						npc   = opnd_q[15:0];
					end
				end
				OP_RET: begin
					if (rdepth_q == '0) begin
						st = ST_UNDER;
					end else begin
						redir      = 1'b1;
						npc        = ret_rd;
						rdepth_nxt = rm1;
					end
				end
				OP_PUSHM, OP_POPVM: begin
					if ((act_q == OP_PUSHM) ? !ram_ok_q : !vram_ok_q) begin
						st = ST_BAD;
					end else if (depth_q == '0) begin
						st = ST_UNDER;
					end else begin
						depth_nxt   = dm1;
						mwr.ram_we  = (act_q == OP_PUSHM);
						mwr.vram_we = (act_q == OP_POPVM);
					end
				end
				OP_POPM: begin
					if (!ram_ok_q) begin
						st = ST_BAD;
					end else begin
						do_push  = 1'b1;
						push_val = ram_rd;
					end
				end
				OP_PUSHVM: begin
					if (!vram_ok_q) begin
						st = ST_BAD;
					end else begin
						do_push  = 1'b1;
						push_val = {56'd0, vram_rd};
					end
				end
				default: st = ST_BAD;
			endcase

			// push onto an unpopped stack
			if (do_push) begin
				if (depth_q >= DS_FULL) begin
					st = ST_OVER;
				end else begin
					ds_we     = 1'b1;
					ds_waddr  = depth_q[DS_AW-1:0];
					ds_wdata  = push_val;
					depth_nxt = depth_q + 1'b1;
				end
			end
		end else if (state_q == S_WAIT && arsp.done) begin
			// push the multi-cycle result over the popped operands
			ds_we     = 1'b1;
			ds_waddr  = depth_q[DS_AW-1:0];
			ds_wdata  = arsp.result;
			depth_nxt = depth_q + 1'b1;
		end
	end

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			depth_q    <= '0;
			rdepth_q   <= '0;
			prog_len_q <= '0;
			done_q     <= 1'b0;
			for (int i = 0; i < REG_COUNT; i++) begin
				regs_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				prog_len_q <= cfg_data;
			end
			if (reg_we) begin
				regs_q[idx_q] <= top0[31:0];
			end
			depth_q  <= depth_nxt;
			rdepth_q <= rdepth_nxt;
			unique case (state_q)
				S_CLEAR: begin
					if (!clearing) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (go_arith) begin
						state_q <= S_WAIT;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					if (arsp.done) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
			endcase
		end
	end

	// hold the command fields
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q     <= opcode_t'(action);
			opnd_q    <= operand;
			has_q     <= has_operand;
			pc_q      <= current_pc;
			inval_q   <= input_value;
			inok_q    <= input_ok;
			rv_q      <= rv;
			reg_ok_q  <= reg_ok;
			ram_ok_q  <= reg_ok && (rv[31:RAM_AW] == '0);
			vram_ok_q <= reg_ok && (rv[31:VRAM_AW] == '0);
			idx_q     <= operand[REG_AW-1:0];
			maddr_q   <= rv[VRAM_AW-1:0];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			status_q <= st;
			redir_q  <= redir;
			npc_q    <= npc;
			halt_q   <= halt;
			ov_q     <= ov;
			oval_q   <= oval;
		end else if (state_q == S_WAIT) begin
			status_q <= ST_OK;
			redir_q  <= 1'b0;
			npc_q    <= '0;
			halt_q   <= 1'b0;
			ov_q     <= 1'b0;
			oval_q   <= '0;
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign redirect  = redir_q;
	assign next_pc   = npc_q;
	assign halted    = halt_q;
	assign out_valid = ov_q;
	assign out_value = oval_q;

	`SME_ASSERT(a_done_src, clk, arst_n, done |-> ($past(state_q) == S_EXEC || $past(state_q) == S_WAIT))
	`SME_ASSERT(a_ds_bound, clk, arst_n, depth_q <= DS_FULL)
	`SME_ASSERT(a_rs_bound, clk, arst_n, rdepth_q <= RS_FULL)
	`SME_NEVER(a_no_cmd_in_clear, clk, arst_n, clearing && (state_q != S_CLEAR))

endmodule
